// ===== src/periodic_timer_with_compare_unit_defines.svh =====
// ---------------------------------------------------------------------------
// periodic timer with compare: assertion macros
// shared concurrent assertion forms, clocked and gated by the sync reset
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_WITH_COMPARE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_WITH_COMPARE_UNIT_DEFINES_SVH

// same-cycle implication
`define PTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== src/ptc_pkg.sv =====
// ---------------------------------------------------------------------------
// ptc_pkg
// types, register map and control bit layout of the periodic timer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptc_pkg;

    localparam int COUNT_WIDTH_DEF    = 32;
    localparam int PRESCALE_WIDTH_DEF = 12;
    localparam int DATA_WIDTH         = 32;
    localparam int CTL_WIDTH          = 26;

    // control bit positions
    localparam int CTL_EN     = 0;
    localparam int CTL_ENMOD  = 1;
    localparam int CTL_OCIEN  = 2;
    localparam int CTL_RLD    = 3;
    localparam int CTL_PS_LSB = 4;
    localparam int CTL_SWR    = 16;
    localparam int CTL_IOVW   = 17;
    localparam int CTL_SRC_LSB = 24;

    // bits that survive a soft reset: EN, ENMOD, DBGEN, WAITEN, DOZEN, STOPEN
    localparam logic [CTL_WIDTH-1:0] CTL_SWR_KEEP = 26'h03c0003;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        SRC_NONE     = 2'd0,
        SRC_PERIPH   = 2'd1,
        SRC_HIGHFREQ = 2'd2,
        SRC_LOWFREQ  = 2'd3
    } t_clk_src;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_STATUS  = 3'd1;
    localparam logic [2:0] REG_LOAD    = 3'd2;
    localparam logic [2:0] REG_COMPARE = 3'd3;
    localparam logic [2:0] REG_COUNT   = 3'd4;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [2:0]            reg_index;
        logic [DATA_WIDTH-1:0] write_data;
        logic [2:0]            clock_pulses;
    } t_in_item;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq_level;
        logic                  status_out;
    } t_result;

endpackage

// ===== src/ptc_in_reg.sv =====
// ---------------------------------------------------------------------------
// ptc_in_reg
// input register stage, holds one transaction until the core consumes it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ptc_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output ptc_pkg::t_in_item o_item
);
    import ptc_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/ptc_timer_core.sv =====
// ---------------------------------------------------------------------------
// ptc_timer_core
// timer state registers and single-pass update for tick, read and write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_timer_core #(
    parameter int COUNT_WIDTH    = ptc_pkg::COUNT_WIDTH_DEF,
    parameter int PRESCALE_WIDTH = ptc_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ptc_pkg::t_in_item i_item,
    output ptc_pkg::t_result  o_result
);
    import ptc_pkg::*;

    localparam int EXT_WIDTH = COUNT_WIDTH + DATA_WIDTH;

    logic [CTL_WIDTH-1:0]      r_ctl,  n_ctl;
    logic                      r_flag, n_flag;
    logic [DATA_WIDTH-1:0]     r_load, n_load;
    logic [DATA_WIDTH-1:0]     r_cmp,  n_cmp;
    logic [COUNT_WIDTH-1:0]    r_cnt,  n_cnt;
    logic [PRESCALE_WIDTH-1:0] r_ps,   n_ps;
    logic [DATA_WIDTH-1:0]     rd;

    // zero-extended views for mixed-width compare and copy
    logic [EXT_WIDTH-1:0] cnt_ext;
    logic [EXT_WIDTH-1:0] load_ext;
    logic [EXT_WIDTH-1:0] wdata_ext;

    assign cnt_ext   = {{DATA_WIDTH{1'b0}}, r_cnt};
    assign load_ext  = {{COUNT_WIDTH{1'b0}}, r_load};
    assign wdata_ext = {{COUNT_WIDTH{1'b0}}, i_item.write_data};

    always_comb begin
        logic                      pulse;
        logic [PRESCALE_WIDTH-1:0] div;
        logic [COUNT_WIDTH-1:0]    cnt_step;
        logic [EXT_WIDTH-1:0]      step_ext;
        logic [EXT_WIDTH-1:0]      cmp_ext;
        logic [EXT_WIDTH-1:0]      nload_ext;
        logic [CTL_WIDTH-1:0]      wctl;

        n_ctl  = r_ctl;
        n_flag = r_flag;
        n_load = r_load;
        n_cmp  = r_cmp;
        n_cnt  = r_cnt;
        n_ps   = r_ps;
        rd     = '0;

        // selected clock source pulse
        case (t_clk_src'(r_ctl[CTL_SRC_LSB +: 2]))
            SRC_PERIPH:   pulse = i_item.clock_pulses[0];
            SRC_HIGHFREQ: pulse = i_item.clock_pulses[1];
            SRC_LOWFREQ:  pulse = i_item.clock_pulses[2];
            default:      pulse = 1'b0;
        endcase

        div     = r_ctl[CTL_PS_LSB +: PRESCALE_WIDTH];
        cmp_ext = {{COUNT_WIDTH{1'b0}}, r_cmp};

        // one decrement; at zero, reload from the load register or, without RLD, wrap to all ones
        if (r_cnt == '0) begin
            cnt_step = r_ctl[CTL_RLD] ? load_ext[COUNT_WIDTH-1:0] : '1;
        end else begin
            cnt_step = r_cnt - COUNT_WIDTH'(1);
        end
        step_ext = {{DATA_WIDTH{1'b0}}, cnt_step};

        wctl      = i_item.write_data[CTL_WIDTH-1:0];
        nload_ext = '0;

        case (i_item.opcode)
            OP_TICK: begin
                if (r_ctl[CTL_EN] && pulse) begin
                    if (r_ps >= div) begin
                        n_ps  = '0;
                        n_cnt = cnt_step;
                        if (r_ctl[CTL_OCIEN] && step_ext == cmp_ext) begin
                            n_flag = 1'b1;
                        end
                    end else begin
                        n_ps = r_ps + PRESCALE_WIDTH'(1);
                    end
                end
            end
            OP_READ: begin
                case (i_item.reg_index)
                    REG_CONTROL: rd = DATA_WIDTH'(r_ctl);
                    REG_STATUS:  rd = DATA_WIDTH'(r_flag);
                    REG_LOAD:    rd = r_load;
                    REG_COMPARE: rd = r_cmp;
                    REG_COUNT:   rd = cnt_ext[DATA_WIDTH-1:0];
                    default:     rd = '0;
                endcase
            end
            OP_WRITE: begin
                case (i_item.reg_index)
                    REG_CONTROL: begin
                        n_ctl = wctl;
                        if (wctl[CTL_SWR]) begin
                            n_ctl  = wctl & CTL_SWR_KEEP;
                            n_flag = 1'b0;
                            n_load = '1;
                            n_cmp  = '0;
                            n_cnt  = '1;
                            n_ps   = '0;
                        end
                        nload_ext = {{COUNT_WIDTH{1'b0}}, n_load};
                        // enable rising edge with a clock source selected
                        if (n_ctl[CTL_SRC_LSB +: 2] != SRC_NONE && n_ctl[CTL_EN]
                            && !r_ctl[CTL_EN]) begin
                            n_ps = '0;
                            if (n_ctl[CTL_ENMOD]) begin
                                n_cnt = n_ctl[CTL_RLD] ? nload_ext[COUNT_WIDTH-1:0] : '1;
                            end
                        end
                    end
                    REG_STATUS: begin
                        if (i_item.write_data[0]) begin
                            n_flag = 1'b0;
                        end
                    end
                    REG_LOAD: begin
                        n_load = i_item.write_data;
                        if (r_ctl[CTL_IOVW]) begin
                            n_cnt = wdata_ext[COUNT_WIDTH-1:0];
                        end
                    end
                    REG_COMPARE: n_cmp = i_item.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_flag <= 1'b0;
            r_load <= '1;
            r_cmp  <= '0;
            r_cnt  <= '1;
            r_ps   <= '0;
        end else if (i_fire) begin
            r_ctl  <= n_ctl;
            r_flag <= n_flag;
            r_load <= n_load;
            r_cmp  <= n_cmp;
            r_cnt  <= n_cnt;
            r_ps   <= n_ps;
        end
    end

    assign o_result.read_data  = rd;
    assign o_result.irq_level  = n_flag && n_ctl[CTL_EN] && n_ctl[CTL_OCIEN];
    assign o_result.status_out = n_flag;

endmodule

// ===== src/periodic_timer_with_compare_unit.sv =====
// ---------------------------------------------------------------------------
// periodic_timer_with_compare_unit
// register-mapped periodic down-counter with prescaler and compare interrupt
// ---------------------------------------------------------------------------
//
//  channel   valid     ready     payload
//  -------   -------   -------   -----------------------------------------------
//  input     i_valid   o_ready   i_opcode i_reg_index i_write_data i_clock_pulses
//  output    o_valid   i_ready   o_read_data o_irq_level o_status_out
//
//  one transaction per cycle sustained unless the output stalls; output valid
//  rises after input acceptance via the input register, then the result register
//  the timer state updates in the same cycle the result register loads
//  synchronous active-low reset clears control, status, compare and
//  prescaler, and sets load and count to all ones
//  a stalled output holds both stages; the input stays ready while the
//  input register is empty
//
`timescale 1ns / 1ps

`include "periodic_timer_with_compare_unit_defines.svh"

module periodic_timer_with_compare_unit #(
    parameter int COUNT_WIDTH    = ptc_pkg::COUNT_WIDTH_DEF,
    parameter int PRESCALE_WIDTH = ptc_pkg::PRESCALE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transaction
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [2:0]                     i_reg_index,
    input  logic [ptc_pkg::DATA_WIDTH-1:0] i_write_data,
    input  logic [2:0]                     i_clock_pulses,
    // result transaction
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ptc_pkg::DATA_WIDTH-1:0] o_read_data,
    output logic                           o_irq_level,
    output logic                           o_status_out
);
    import ptc_pkg::*;

    t_in_item in_item;
    t_in_item stage_item;
    logic     stage_valid;
    logic     advance;
    logic     fire;
    t_result  core_result;

    logic     r_out_valid;
    logic     n_out_valid;
    t_result  r_out;

    assign in_item.opcode       = i_opcode;
    assign in_item.reg_index    = i_reg_index;
    assign in_item.write_data   = i_write_data;
    assign in_item.clock_pulses = i_clock_pulses;

    // result register free or draining this cycle
    assign advance = !r_out_valid || i_ready;
    // staged transaction goes through the core into the result register
    assign fire    = stage_valid && advance;

    ptc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    ptc_timer_core #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .PRESCALE_WIDTH (PRESCALE_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    // result register valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded with the state update
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_out.read_data;
    assign o_irq_level  = r_out.irq_level;
    assign o_status_out = r_out.status_out;

    // an empty pipeline must take a transaction
    `PTC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid && !stage_valid, o_ready)
    // irq is never raised without the status flag
    `PTC_ASSERT_NOW(a_irq_needs_status, i_clk, i_rst_n, o_valid && o_irq_level, o_status_out)
    // a staged transaction that fires shows up as a result next cycle
    `PTC_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, fire, o_valid)

endmodule

// ===== verif/tb_periodic_timer_with_compare_unit.sv =====
// ---------------------------------------------------------------------------
// tb_periodic_timer_with_compare_unit
// self-checking bench: a shadow copy of the timer registers predicts every
// response; directed register and compare cases come first, then phases of
// timer setup followed by ticks, reads and writes, with random idling on both
// channels, a long receiver hold and a drain pause
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_timer_with_compare_unit;

    import ptc_pkg::*;

    localparam int CNT_W = COUNT_WIDTH_DEF;
    localparam int PS_W  = PRESCALE_WIDTH_DEF;
    localparam int unsigned PS_MAX = (1 << PS_W) - 1;

    localparam int TOTAL_ITEMS      = 950;
    // from here on neither side idles
    localparam int QUIET_TAIL_START = TOTAL_ITEMS - 120;
    localparam int DRAIN_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 200000;

    // pulse flags of the three clock sources
    localparam logic [2:0] PULSE_PERIPH   = 3'b001;
    localparam logic [2:0] PULSE_HIGHFREQ = 3'b010;
    localparam logic [2:0] PULSE_LOWFREQ  = 3'b100;
    localparam logic [2:0] PULSE_ALL      = 3'b111;

    // indexes with no register behind them
    localparam logic [2:0] REG_HOLE = 3'd6;
    localparam logic [2:0] REG_LAST = 3'd7;

    // status write: bit0 clears the compare flag
    localparam logic [31:0] STATUS_CLEAR = 32'h0000_0001;

    // -----------------------------------------------------------------------
    // shadow timer and pending responses
    // -----------------------------------------------------------------------
    class timer_scoreboard;
        bit [CTL_WIDTH-1:0]  ctl;
        bit                  cmp_flag;
        bit [DATA_WIDTH-1:0] load_val;
        bit [DATA_WIDTH-1:0] cmp_val;
        bit [CNT_W-1:0]      cnt;
        bit [PS_W-1:0]       psc;
        t_result             pending_responses[$];
        int                  failures;

        function new();
            ctl      = '0;
            cmp_flag = 1'b0;
            load_val = '1;
            cmp_val  = '0;
            cnt      = '1;
            psc      = '0;
            failures = 0;
        endfunction

        // value the count takes on a wrap or an enable-edge preload
        function bit [CNT_W-1:0] reload_value();
            return ctl[CTL_RLD] ? load_val[CNT_W-1:0] : '1;
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction

        // advance the shadow timer by one accepted transaction
        function void note_access(t_in_item acc);
            bit [CTL_WIDTH-1:0] old_ctl;
            t_clk_src           src;
            t_result            rsp;
            rsp = '0;
            case (acc.opcode)
                OP_TICK: begin
                    src = t_clk_src'(ctl[CTL_SRC_LSB +: 2]);
                    if (ctl[CTL_EN] && src != SRC_NONE && acc.clock_pulses[src - 1]) begin
                        if (psc >= ctl[CTL_PS_LSB +: PS_W]) begin
                            psc = '0;
                            if (cnt == '0)
                                cnt = reload_value();
                            else
                                cnt = cnt - 1'b1;
                            if (ctl[CTL_OCIEN] && cnt == cmp_val)
                                cmp_flag = 1'b1;
                        end else begin
                            psc = psc + 1'b1;
                        end
                    end
                end
                OP_READ: begin
                    case (acc.reg_index)
                        REG_CONTROL: rsp.read_data = DATA_WIDTH'(ctl);
                        REG_STATUS:  rsp.read_data = DATA_WIDTH'(cmp_flag);
                        REG_LOAD:    rsp.read_data = load_val;
                        REG_COMPARE: rsp.read_data = cmp_val;
                        REG_COUNT:   rsp.read_data = cnt[DATA_WIDTH-1:0];
                        default:     rsp.read_data = '0;
                    endcase
                end
                OP_WRITE: begin
                    case (acc.reg_index)
                        REG_CONTROL: begin
                            old_ctl = ctl;
                            ctl     = acc.write_data[CTL_WIDTH-1:0];
                            if (ctl[CTL_SWR]) begin
                                ctl      = ctl & CTL_SWR_KEEP;
                                cmp_flag = 1'b0;
                                load_val = '1;
                                cmp_val  = '0;
                                cnt      = '1;
                                psc      = '0;
                            end
                            // enable edge only counts with a clock source
                            if (ctl[CTL_SRC_LSB +: 2] != SRC_NONE && ctl[CTL_EN]
                                    && !old_ctl[CTL_EN]) begin
                                psc = '0;
                                if (ctl[CTL_ENMOD])
                                    cnt = reload_value();
                            end
                        end
                        REG_STATUS: begin
                            if (acc.write_data[0])
                                cmp_flag = 1'b0;
                        end
                        REG_LOAD: begin
                            load_val = acc.write_data;
                            if (ctl[CTL_IOVW])
                                cnt = acc.write_data[CNT_W-1:0];
                        end
                        REG_COMPARE: cmp_val = acc.write_data;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            rsp.irq_level  = cmp_flag && ctl[CTL_EN] && ctl[CTL_OCIEN];
            rsp.status_out = cmp_flag;
            pending_responses.push_back(rsp);
        endfunction

        function void check_response(t_result got);
            t_result want;
            if (pending_responses.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: response with none pending: rd=%h irq=%b st=%b",
                             $realtime, got.read_data, got.irq_level, got.status_out);
                return;
            end
            want = pending_responses.pop_front();
            if (got.read_data !== want.read_data || got.irq_level !== want.irq_level
                    || got.status_out !== want.status_out) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: rd exp %h got %h, irq exp %b got %b, st exp %b got %b",
                             $realtime, want.read_data, got.read_data, want.irq_level,
                             got.irq_level, want.status_out, got.status_out);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, reset and dut
    // -----------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode       = OP_TICK;
    logic [2:0]  i_reg_index    = REG_CONTROL;
    logic [31:0] i_write_data   = '0;
    logic [2:0]  i_clock_pulses = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [31:0] o_read_data;
    logic        o_irq_level;
    logic        o_status_out;

    timer_scoreboard sb;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    int  rx_stall_left = 0;
    // long receiver hold, picked up by the receiver process
    int  hold_request  = 0;
    bit  idling_on     = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    periodic_timer_with_compare_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .i_clock_pulses (i_clock_pulses),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_data    (o_read_data),
        .o_irq_level    (o_irq_level),
        .o_status_out   (o_status_out)
    );

    // -----------------------------------------------------------------------
    // receiver: random stall bursts, or a long hold when one is requested
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            i_ready <= 1'b0;
        end else if (hold_request > 0) begin
            // hold off long enough for both stages to fill and stall the input
            rx_stall_left = hold_request - 1;
            hold_request  = 0;
            i_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(0, 9);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result monitor: values seen here are the ones before this edge's updates
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_response(t_result'({o_read_data, o_irq_level, o_status_out}));
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // -----------------------------------------------------------------------
    // driver tasks
    // -----------------------------------------------------------------------
    function automatic logic [31:0] control_word(bit en, bit enmod, bit ocien, bit rld,
                                                 bit iovw, int unsigned ps_div,
                                                 t_clk_src src);
        logic [31:0] w;
        w = '0;
        w[CTL_EN]                 = en;
        w[CTL_ENMOD]              = enmod;
        w[CTL_OCIEN]              = ocien;
        w[CTL_RLD]                = rld;
        w[CTL_IOVW]               = iovw;
        w[CTL_PS_LSB +: PS_W]     = ps_div[PS_W-1:0];
        w[CTL_SRC_LSB +: 2]       = src;
        return w;
    endfunction

    // offer one transaction, hold it until accepted, then record it
    task automatic send_access(input logic [1:0] op, input logic [2:0] idx,
                               input logic [31:0] data, input logic [2:0] pulses);
        t_in_item acc;
        if (items_sent >= QUIET_TAIL_START)
            idling_on = 1'b0;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_reg_index    <= idx;
        i_write_data   <= data;
        i_clock_pulses <= pulses;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        acc.opcode       = op;
        acc.reg_index    = idx;
        acc.write_data   = data;
        acc.clock_pulses = pulses;
        sb.note_access(acc);
        items_sent++;
    endtask

    // sender goes quiet until every response is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial begin
        int          phase;
        int          pick;
        int          src_bit;
        bit          quiet;
        t_clk_src    src;
        logic [31:0] ctl_word;
        logic [2:0]  pulses;
        int unsigned reload_span;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values and unknown index
        send_access(OP_READ, REG_CONTROL, '0, '0);
        send_access(OP_READ, REG_LOAD, '0, '0);
        send_access(OP_READ, REG_COUNT, '0, '0);
        send_access(OP_READ, REG_LAST, '1, PULSE_ALL);
        // disabled timer ignores ticks
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_ALL);
        // enable with preload to all ones, then count down onto compare
        send_access(OP_WRITE, REG_COMPARE, 32'hffff_fffd, '0);
        send_access(OP_WRITE, REG_CONTROL,
                    control_word(1, 1, 1, 0, 0, 0, SRC_PERIPH), '0);
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_PERIPH);
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_PERIPH);
        // status write without bit0 keeps the flag, with bit0 clears it
        send_access(OP_WRITE, REG_STATUS, 32'hffff_fffe, '0);
        send_access(OP_WRITE, REG_STATUS, STATUS_CLEAR, '0);
        // already enabled: no edge; load write overwrites the count
        send_access(OP_WRITE, REG_CONTROL,
                    control_word(1, 1, 1, 1, 1, 0, SRC_PERIPH), '0);
        send_access(OP_WRITE, REG_LOAD, 32'h0000_0001, '0);
        send_access(OP_WRITE, REG_COMPARE, '0, '0);
        // pulse on the wrong sources only
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_HIGHFREQ | PULSE_LOWFREQ);
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_PERIPH);
        // wrap at zero reloads from the load register
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_PERIPH);
        send_access(OP_WRITE, REG_COUNT, 32'h0000_1234, '0);
        send_access(OP_WRITE, REG_HOLE, '1, '0);
        send_access(OP_READ, REG_COUNT, '0, '0);
        // soft reset with every bit set, then a tick with no clock source
        send_access(OP_WRITE, REG_CONTROL, '1, PULSE_ALL);
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_ALL);
        send_access(OP_READ, REG_CONTROL, '0, '0);
        // count equal to compare at enable time does not raise the flag
        send_access(OP_WRITE, REG_CONTROL, '0, '0);
        send_access(OP_WRITE, REG_COMPARE, '1, '0);
        send_access(OP_WRITE, REG_CONTROL,
                    control_word(1, 1, 1, 1, 0, PS_MAX, SRC_LOWFREQ), '0);
        send_access(OP_TICK, REG_CONTROL, '0, PULSE_LOWFREQ);
        send_access(OP_READ, REG_STATUS, '0, '0);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            phase++;
            quiet     = ($urandom_range(0, 4) == 0);
            idling_on = !quiet && items_sent < QUIET_TAIL_START;

            if (phase == 3 || $urandom_range(0, 9) == 0)
                wait_drained();
            if (items_sent < QUIET_TAIL_START && (phase == 2 || $urandom_range(0, 24) == 0))
                hold_request = $urandom_range(40, 80);

            if ($urandom_range(0, 4) == 0) begin
                // noise: anything the fields allow
                repeat ($urandom_range(10, 30))
                    send_access(2'($urandom_range(OP_TICK, OP_WRITE)),
                                3'($urandom_range(REG_CONTROL, REG_LAST)),
                                $urandom, 3'($urandom_range(0, 7)));
            end else begin
                // well-formed setup: an optional disable, then load, compare, enable
                src         = t_clk_src'($urandom_range(SRC_PERIPH, SRC_LOWFREQ));
                src_bit     = int'(src) - 1;
                reload_span = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24);
                if ($urandom_range(0, 4) != 0) begin
                    ctl_word = control_word(0, 1, 1, 0, 0, 0, src);
                    ctl_word[31:CTL_WIDTH] = 6'($urandom);
                    send_access(OP_WRITE, REG_CONTROL, ctl_word, 3'($urandom_range(0, 7)));
                end
                send_access(OP_WRITE, REG_LOAD, reload_span, 3'($urandom_range(0, 7)));
                send_access(OP_WRITE, REG_COMPARE, $urandom_range(0, reload_span),
                            3'($urandom_range(0, 7)));
                ctl_word = control_word(1, $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0,
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                        ($urandom_range(0, 19) == 0) ? $urandom
                                                                     : $urandom_range(0, 3),
                                        src);
                ctl_word[23:18]        = 6'($urandom);
                ctl_word[31:CTL_WIDTH] = 6'($urandom);
                ctl_word[CTL_SWR]      = ($urandom_range(0, 9) == 0);
                send_access(OP_WRITE, REG_CONTROL, ctl_word, 3'($urandom_range(0, 7)));

                // run the timer with mostly ticks of the selected source
                repeat ($urandom_range(20, 60)) begin
                    pick   = $urandom_range(0, 99);
                    pulses = 3'($urandom_range(0, 7));
                    if (pick < 70) begin
                        if ($urandom_range(0, 3) != 0)
                            pulses[src_bit] = 1'b1;
                        send_access(OP_TICK, 3'($urandom_range(REG_CONTROL, REG_LAST)),
                                    $urandom, pulses);
                    end else if (pick < 85) begin
                        send_access(OP_READ, 3'($urandom_range(REG_CONTROL, REG_LAST)),
                                    $urandom, pulses);
                    end else if (pick < 90) begin
                        send_access(OP_WRITE, REG_STATUS, $urandom, pulses);
                    end else if (pick < 95) begin
                        send_access(OP_WRITE, 3'($urandom_range(REG_LOAD, REG_COMPARE)),
                                    $urandom_range(0, reload_span), pulses);
                    end else if (pick < 98) begin
                        send_access(OP_WRITE, 3'($urandom_range(REG_COUNT, REG_LAST)),
                                    $urandom, pulses);
                    end else begin
                        // toggle enable and the rest of the control word
                        send_access(OP_WRITE, REG_CONTROL, $urandom, pulses);
                    end
                end
            end
        end

        // final drain, then a wait of DRAIN_CYCLES for anything stray
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
